// ===== sv/jsd_pkg.sv =====
// Package for the joystick state store: store sizes, opcodes, Q1.15 constants,
// state and control types, and the types shared with the axis conditioning unit.
// Depends on nothing.
package jsd_pkg;

    // Store depths.
    localparam int NUM_AXES    = 16;
    localparam int NUM_BUTTONS = 64;
    localparam int NUM_HATS    = 4;

    // Buttons and hats share one memory, so its depth covers both.
    localparam int KEY_DEPTH = (NUM_BUTTONS > NUM_HATS) ? NUM_BUTTONS : NUM_HATS;
    localparam int AXIS_AW   = (NUM_AXES > 1) ? $clog2(NUM_AXES) : 1;
    localparam int KEY_AW    = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;

    // Field widths.
    localparam int OP_W     = 3;
    localparam int SLOT_W   = 6;
    localparam int SAMPLE_W = 16;
    localparam int HAT_W    = 4;
    localparam int ZONE_W   = 15;

    // Layout of a word in the button and hat memory.
    localparam int KEY_W       = HAT_W + 1;
    localparam int KEY_BTN_BIT = 0;
    localparam int KEY_HAT_LSB = 1;

    // Opcodes.
    localparam logic [OP_W-1:0] OP_AXIS_MOTION = 3'd0;
    localparam logic [OP_W-1:0] OP_BUTTON_DOWN = 3'd1;
    localparam logic [OP_W-1:0] OP_BUTTON_UP   = 3'd2;
    localparam logic [OP_W-1:0] OP_HAT_MOTION  = 3'd3;
    localparam logic [OP_W-1:0] OP_READ_AXIS   = 3'd4;
    localparam logic [OP_W-1:0] OP_READ_BUTTON = 3'd5;
    localparam logic [OP_W-1:0] OP_READ_HAT    = 3'd6;

    // Configuration register indexes.
    localparam logic CFG_DEADZONE = 1'b0;
    localparam logic CFG_END_ZONE = 1'b1;

    // Q1.15 constants; the two unit constants are 18 bits signed for the zone comparisons.
    localparam logic signed [17:0] ONE_Q15     = 18'sd32768;
    localparam logic signed [17:0] MINUS_ONE_Q = -18'sd32768;
    localparam logic signed [15:0] POS_FULL    = 16'sh7FFF;
    localparam logic signed [15:0] NEG_FULL    = 16'sh8000;

    // Restoring divider: one quotient bit per step.
    localparam int DIV_STEPS  = 15;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

    // Main sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_WAIT
    } seq_state_t;

    // Conditioning unit states.
    typedef enum logic {
        C_IDLE,
        C_DIV
    } cond_state_t;

    // Request into the conditioning unit.
    typedef struct packed {
        logic                       start;
        logic signed [SAMPLE_W-1:0] sample;
        logic [ZONE_W-1:0]          dz;
        logic [ZONE_W-1:0]          ez;
    } cond_req_t;

    // Response from the conditioning unit.
    typedef struct packed {
        logic                       done;
        logic signed [SAMPLE_W-1:0] level;
    } cond_rsp_t;

    // Control decoded by the sequencer in the execute and wait states.
    typedef struct packed {
        logic axis_we;
        logic key_we;
        logic cond_start;
        logic res_load;
    } exec_ctl_t;

endpackage

// ===== sv/joystick_state_with_deadzone.sv =====
// Top level of the joystick state store: axis memory, button and hat memory,
// the read-modify-write sequencer and the configuration registers.
// Depends on jsd_pkg, jsd_ram and jsd_axis_cond.
//
//  Channel   Handshake                Payload
//  --------  -----------------------  ---------------------------------------------
//  command   start high, busy low     opcode, slot, axis_sample, hat_bits
//  result    result_strobe, 1 cycle   axis_level, button_pressed, hat_state, read_done
//  config    cfg_we                   cfg_index, cfg_data
//
//  Every transaction reads its store entry in the accept cycle and acts on it in the
//  next one. Apart from an axis read of a slot in the store, busy is high only in the
//  execute state and the result strobe rises as it falls. Such an axis read always
//  waits on the conditioning unit: busy stays high through the execute and wait states,
//  and the strobe rises as it falls. When a rescale is needed, the wait lasts while the
//  divider runs, one quotient bit per cycle.
//  Reset clears the valid bits of both memories at once, so no clearing pass is run.
//  The receiver cannot stall; a new command is taken while a result is on show.
module joystick_state_with_deadzone
    import jsd_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [OP_W-1:0]            opcode,
    input  logic [SLOT_W-1:0]          slot,
    input  logic signed [SAMPLE_W-1:0] axis_sample,
    input  logic [HAT_W-1:0]           hat_bits,
    output logic                       result_strobe,
    output logic signed [SAMPLE_W-1:0] axis_level,
    output logic                       button_pressed,
    output logic [HAT_W-1:0]           hat_state,
    output logic                       read_done,
    input  logic                       cfg_we,
    input  logic                       cfg_index,
    input  logic [ZONE_W-1:0]          cfg_data
);

    seq_state_t state_reg, state_next;

    logic [OP_W-1:0]            op_reg;
    logic [SLOT_W-1:0]          slot_reg;
    logic signed [SAMPLE_W-1:0] sample_reg;
    logic [HAT_W-1:0]           hat_reg;
    logic [ZONE_W-1:0]          dz_reg, ez_reg;

    logic [NUM_AXES-1:0]  axis_valid_reg, axis_valid_next;
    logic [KEY_DEPTH-1:0] key_valid_reg, key_valid_next;

    logic signed [SAMPLE_W-1:0] level_reg, level_next;
    logic                       pressed_reg, pressed_next;
    logic [HAT_W-1:0]           hat_state_reg, hat_state_next;
    logic                       read_done_reg, read_done_next;
    logic                       strobe_reg;

    logic [AXIS_AW-1:0]  axis_raddr, axis_waddr;
    logic [KEY_AW-1:0]   key_raddr, key_waddr;
    logic [SAMPLE_W-1:0] axis_rdata;
    logic [KEY_W-1:0]    key_rdata, key_wdata;

    logic            axis_in_range, btn_in_range, hat_in_range;
    logic [15:0]     axis_word;
    logic [KEY_W-1:0] key_word;
    logic            accept;

    exec_ctl_t ctl;
    cond_req_t cond_req;
    cond_rsp_t cond_rsp;

    assign accept = start && (state_reg == ST_IDLE);
    assign busy   = state_reg != ST_IDLE;

    // Reads are issued straight from the command ports in the accept cycle.
    assign axis_raddr = AXIS_AW'(slot);
    assign key_raddr  = KEY_AW'(slot);
    assign axis_waddr = AXIS_AW'(slot_reg);
    assign key_waddr  = KEY_AW'(slot_reg);

    jsd_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (NUM_AXES)
    ) u_axis_ram (
        .clk   (clk),
        .we    (ctl.axis_we),
        .waddr (axis_waddr),
        .wdata (sample_reg),
        .raddr (axis_raddr),
        .rdata (axis_rdata)
    );

    jsd_ram #(
        .WIDTH (KEY_W),
        .DEPTH (KEY_DEPTH)
    ) u_key_ram (
        .clk   (clk),
        .we    (ctl.key_we),
        .waddr (key_waddr),
        .wdata (key_wdata),
        .raddr (key_raddr),
        .rdata (key_rdata)
    );

    // Range checks and store words, with unwritten entries reading as reset.
    always_comb
    begin
        axis_in_range = int'(slot_reg) < NUM_AXES;
        btn_in_range  = int'(slot_reg) < NUM_BUTTONS;
        hat_in_range  = int'(slot_reg) < NUM_HATS;
        axis_word     = '0;
        key_word      = '0;
        if (axis_in_range && axis_valid_reg[axis_waddr])
        begin
            axis_word = axis_rdata;
        end
        if ((btn_in_range || hat_in_range) && key_valid_reg[key_waddr])
        begin
            key_word = key_rdata;
        end
    end

    assign cond_req.start  = ctl.cond_start;
    assign cond_req.sample = signed'(axis_word);
    assign cond_req.dz     = dz_reg;
    assign cond_req.ez     = ez_reg;

    jsd_axis_cond u_cond (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (cond_req),
        .rsp   (cond_rsp)
    );

    // Next state of the sequencer.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if ((op_reg == OP_READ_AXIS) && axis_in_range)
                begin
                    state_next = ST_WAIT;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_WAIT:
            begin
                if (cond_rsp.done)
                begin
                    state_next = ST_IDLE;
                end
            end
        endcase
    end

    // Sequencer outputs: store writes, divider start and result values.
    always_comb
    begin
        ctl            = '0;
        key_wdata      = key_word;
        level_next     = '0;
        pressed_next   = 1'b0;
        hat_state_next = '0;
        read_done_next = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
            end
            ST_EXEC:
            begin
                ctl.res_load = 1'b1;
                case (op_reg)
                    OP_AXIS_MOTION:
                    begin
                        ctl.axis_we = axis_in_range;
                    end
                    OP_BUTTON_DOWN:
                    begin
                        ctl.key_we              = btn_in_range;
                        key_wdata[KEY_BTN_BIT] = 1'b1;
                    end
                    OP_BUTTON_UP:
                    begin
                        ctl.key_we              = btn_in_range;
                        key_wdata[KEY_BTN_BIT] = 1'b0;
                    end
                    OP_HAT_MOTION:
                    begin
                        ctl.key_we                                = hat_in_range;
                        key_wdata[KEY_HAT_LSB +: HAT_W] = hat_reg;
                    end
                    OP_READ_AXIS:
                    begin
                        read_done_next = 1'b1;
                        if (axis_in_range)
                        begin
                            ctl.cond_start = 1'b1;
                            ctl.res_load   = 1'b0;
                        end
                    end
                    OP_READ_BUTTON:
                    begin
                        read_done_next = 1'b1;
                        pressed_next   = btn_in_range && key_word[KEY_BTN_BIT];
                    end
                    OP_READ_HAT:
                    begin
                        read_done_next = 1'b1;
                        if (hat_in_range)
                        begin
                            hat_state_next = key_word[KEY_HAT_LSB +: HAT_W];
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            ST_WAIT:
            begin
                ctl.res_load   = cond_rsp.done;
                level_next     = cond_rsp.level;
                read_done_next = 1'b1;
            end
        endcase
    end

    // Valid bits follow the store writes.
    always_comb
    begin
        axis_valid_next = axis_valid_reg;
        key_valid_next  = key_valid_reg;
        if (ctl.axis_we)
        begin
            axis_valid_next[axis_waddr] = 1'b1;
        end
        if (ctl.key_we)
        begin
            key_valid_next[key_waddr] = 1'b1;
        end
    end

    // Control state, valid bits and configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            strobe_reg     <= 1'b0;
            axis_valid_reg <= '0;
            key_valid_reg  <= '0;
            dz_reg         <= '0;
            ez_reg         <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            strobe_reg     <= ctl.res_load;
            axis_valid_reg <= axis_valid_next;
            key_valid_reg  <= key_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_DEADZONE: dz_reg <= cfg_data;
                    CFG_END_ZONE: ez_reg <= cfg_data;
                endcase
            end
        end
    end

    // Command capture and result payload.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg     <= opcode;
            slot_reg   <= slot;
            sample_reg <= axis_sample;
            hat_reg    <= hat_bits;
        end
        if (ctl.res_load)
        begin
            level_reg     <= level_next;
            pressed_reg   <= pressed_next;
            hat_state_reg <= hat_state_next;
            read_done_reg <= read_done_next;
        end
    end

    assign result_strobe  = strobe_reg;
    assign axis_level     = level_reg;
    assign button_pressed = pressed_reg;
    assign hat_state      = hat_state_reg;
    assign read_done      = read_done_reg;

endmodule

// ===== sv/jsd_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing.
module jsd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/jsd_axis_cond.sv =====
// Axis conditioning unit: deadzone, end zone and rescale of one Q1.15 sample,
// with a restoring divider that produces one quotient bit per cycle.
// Depends on jsd_pkg.
module jsd_axis_cond
    import jsd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cond_req_t req,
    output cond_rsp_t rsp
);

    cond_state_t state_reg, state_next;

    logic [16:0]          rem_reg, rem_next;
    logic [16:0]          den_reg, den_next;
    logic [14:0]          quo_reg, quo_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 neg_reg, neg_next;
    logic signed [15:0]   level_reg, level_next;
    logic                 done_reg, done_next;

    logic signed [17:0] v18, dz18, ez18, mag18, num18, den18, nmag18;
    logic [16:0]        nmag17, den17;
    logic               is_below, is_pos_sat, is_neg_sat, is_null, is_ovf;
    logic signed [15:0] imm_level;
    logic               is_imm;

    logic [17:0] rem_sh;
    logic [17:0] den_ext;
    logic        step_ge;
    logic [16:0] rem_step;
    logic [14:0] quo_step;
    logic [15:0] quo_mag;
    logic        last_step;

    // Classification of the sample against both zones.
    always_comb
    begin
        v18    = 18'(req.sample);
        dz18   = signed'({3'b000, req.dz});
        ez18   = signed'({3'b000, req.ez});
        mag18  = (v18 < 18'sd0) ? -v18 : v18;
        num18  = (v18 > 18'sd0) ? (v18 - dz18) : (v18 + dz18);
        den18  = ONE_Q15 - dz18 - ez18;
        nmag18 = (num18 < 18'sd0) ? -num18 : num18;
        nmag17 = nmag18[16:0];
        den17  = den18[16:0];

        is_below   = mag18 < dz18;
        is_pos_sat = (v18 + ez18) > ONE_Q15;
        is_neg_sat = (v18 - ez18) < MINUS_ONE_Q;
        is_null    = (num18 == 18'sd0) || (den18 <= 18'sd0);
        is_ovf     = nmag17 >= den17;

        // A quotient of full scale or more saturates, so only a numerator
        // below the divisor needs the divider.
        is_imm    = 1'b1;
        imm_level = 16'sd0;
        priority if (is_below)
        begin
            imm_level = 16'sd0;
        end
        else if (is_pos_sat)
        begin
            imm_level = POS_FULL;
        end
        else if (is_neg_sat)
        begin
            imm_level = NEG_FULL;
        end
        else if (is_null)
        begin
            imm_level = 16'sd0;
        end
        else if (is_ovf)
        begin
            imm_level = (num18 < 18'sd0) ? NEG_FULL : POS_FULL;
        end
        else
        begin
            is_imm = 1'b0;
        end
    end

    // One restoring division step.
    always_comb
    begin
        rem_sh    = {rem_reg, 1'b0};
        den_ext   = {1'b0, den_reg};
        step_ge   = rem_sh >= den_ext;
        rem_step  = step_ge ? 17'(rem_sh - den_ext) : rem_sh[16:0];
        quo_step  = {quo_reg[13:0], step_ge};
        quo_mag   = {1'b0, quo_step};
        last_step = cnt_reg == DIV_CNT_W'(DIV_STEPS - 1);
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            C_IDLE:
            begin
                if (req.start && !is_imm)
                begin
                    state_next = C_DIV;
                end
            end
            C_DIV:
            begin
                if (last_step)
                begin
                    state_next = C_IDLE;
                end
            end
        endcase
    end

    // Datapath and outputs.
    always_comb
    begin
        rem_next   = rem_reg;
        den_next   = den_reg;
        quo_next   = quo_reg;
        cnt_next   = cnt_reg;
        neg_next   = neg_reg;
        level_next = level_reg;
        done_next  = 1'b0;
        unique case (state_reg)
            C_IDLE:
            begin
                if (req.start)
                begin
                    if (is_imm)
                    begin
                        level_next = imm_level;
                        done_next  = 1'b1;
                    end
                    else
                    begin
                        rem_next = nmag17;
                        den_next = den17;
                        quo_next = '0;
                        cnt_next = '0;
                        neg_next = num18 < 18'sd0;
                    end
                end
            end
            C_DIV:
            begin
                rem_next = rem_step;
                quo_next = quo_step;
                cnt_next = cnt_reg + DIV_CNT_W'(1);
                if (last_step)
                begin
                    level_next = neg_reg ? signed'(16'(-quo_mag)) : signed'(quo_mag);
                    done_next  = 1'b1;
                end
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        rem_reg   <= rem_next;
        den_reg   <= den_next;
        quo_reg   <= quo_next;
        cnt_reg   <= cnt_next;
        neg_reg   <= neg_next;
        level_reg <= level_next;
    end

    assign rsp.done  = done_reg;
    assign rsp.level = level_reg;

endmodule
